/* design/arpnc_pkg.sv */
// ----------------------------------------------------------------------------
// ARP neighbor cache package
// Shared sizes, codes and the structs passed along the cache cell row.
// ----------------------------------------------------------------------------
package arpnc_pkg;

  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int IP_W          = 32;
  localparam int MAC_W         = 48;
  localparam int REG_IDX_W     = 2;

  localparam logic [7:0]       BYTE_ONES = 8'hFF;
  localparam logic [MAC_W-1:0] MAC_ONES  = {6{BYTE_ONES}};

  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_NOTE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_LOCAL_IP   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IF_READY   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GATEWAY_IP = 2'd2;

  localparam logic [2:0] ST_SHORT   = 3'd0;
  localparam logic [2:0] ST_BAD_FMT = 3'd1;
  localparam logic [2:0] ST_REQUEST = 3'd2;
  localparam logic [2:0] ST_REPLY   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_NOTED   = 3'd5;
  localparam logic [2:0] ST_LOOKUP  = 3'd6;

  localparam logic [15:0] OPER_REQUEST = 16'd1;
  localparam logic [15:0] OPER_REPLY   = 16'd2;
  localparam logic [15:0] HW_ETHERNET  = 16'd1;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [7:0]  HW_LEN       = 8'd6;
  localparam logic [7:0]  PROTO_LEN    = 8'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic             hit;
    idx_t             hit_idx;
    logic             free;
    idx_t             free_idx;
    logic [MAC_W-1:0] mac;
  } srch_t;

  typedef struct packed {
    logic             en;
    idx_t             idx;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cwr_t;

endpackage

/* design/arpnc_intf.sv */
// ----------------------------------------------------------------------------
// ARP neighbor cache channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface arpnc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        frame_short;
  logic [15:0] hardware_type;
  logic [15:0] protocol_type;
  logic [7:0]  hardware_addr_len;
  logic [7:0]  protocol_addr_len;
  logic [15:0] arp_operation;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] tgt_ip;

  modport source (
    output valid, opcode, frame_short, hardware_type, protocol_type,
           hardware_addr_len, protocol_addr_len, arp_operation, sender_mac,
           sender_ip, tgt_ip,
    input  ready
  );
  modport sink (
    input  valid, opcode, frame_short, hardware_type, protocol_type,
           hardware_addr_len, protocol_addr_len, arp_operation, sender_mac,
           sender_ip, tgt_ip,
    output ready
  );
endinterface

interface arpnc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        send_reply;
  logic [47:0] reply_mac;
  logic [31:0] reply_ip;
  logic        hit;
  logic [47:0] found_mac;
  logic        gw_resolved;
  logic [47:0] gateway_mac;

  modport source (
    output valid, status, send_reply, reply_mac, reply_ip, hit, found_mac,
           gw_resolved, gateway_mac,
    input  ready
  );
  modport sink (
    input  valid, status, send_reply, reply_mac, reply_ip, hit, found_mac,
           gw_resolved, gateway_mac,
    output ready
  );
endinterface

interface arpnc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/arpnc_cell.sv */
// ----------------------------------------------------------------------------
// ARP neighbor cache cell
// Holds one cache entry and forwards the search token to the next cell.
// ----------------------------------------------------------------------------
module arpnc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  arpnc_pkg::idx_t           idx,
  input  arpnc_pkg::srch_t          srch_in,
  output arpnc_pkg::srch_t          srch_out,
  input  arpnc_pkg::cwr_t           wr
);

  logic                        valid;
  logic [arpnc_pkg::IP_W-1:0]  ip;
  logic [arpnc_pkg::MAC_W-1:0] mac;
  arpnc_pkg::srch_t            srch_next;
  logic                        wr_here;

  assign wr_here = wr.en && (wr.idx == idx);

  always_comb begin
    srch_next = srch_in;
    if (!srch_in.hit && valid && (ip == srch_in.ip)) begin
      srch_next.hit     = 1'b1;
      srch_next.hit_idx = idx;
      srch_next.mac     = mac;
    end
    if (!valid && !srch_in.free) begin
      srch_next.free     = 1'b1;
      srch_next.free_idx = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    srch_out <= srch_next;
    if (wr_here) begin
      ip  <= wr.ip;
      mac <= wr.mac;
    end
  end

endmodule

/* design/arp_receive_and_neighbor_cache.sv */
// ----------------------------------------------------------------------------
// ARP receive path with neighbor cache
// Classifies parsed ARP frames, learns sender pairs and answers IP lookups.
// ----------------------------------------------------------------------------
// Items arrive on in_ch: a parsed ARP frame, a manual peer note or a lookup.
// Each beat yields exactly one result beat on out_ch. Registers (local IP,
// interface ready, gateway IP) are written on cfg while no item is being
// processed, and an offered write holds off the input; writing the gateway
// IP clears the resolved flag.
// The cache is a row of CACHE_ENTRIES cells. A search token walks the row
// one cell per cycle, picking up the first matching and the first free
// entry, and the chosen slot is written when the result is registered.
// The result is registered in FINISH after the SCAN states have walked the
// row, and the block then returns to IDLE to accept the next item, so only
// one item is in flight.
// A stalled receiver holds the result in the output register; the block
// still accepts the next item and walks the row, then waits before writing.
// Reset empties the cache and clears the resolved flag, gateway MAC,
// replace pointer and registers.
module arp_receive_and_neighbor_cache (
  input  logic  clk,
  input  logic  rst,
  arpnc_in_if.sink    in_ch,
  arpnc_out_if.source out_ch,
  arpnc_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t                      state;
  arpnc_pkg::idx_t             cnt;
  arpnc_pkg::idx_t             ptr;

  logic [arpnc_pkg::IP_W-1:0]  local_ip;
  logic                        if_ready;
  logic [arpnc_pkg::IP_W-1:0]  gateway_ip;
  logic                        resolved;
  logic [arpnc_pkg::MAC_W-1:0] gw_mac;

  logic [1:0]                  item_op;
  logic                        item_short;
  logic                        item_fmt_ok;
  logic [15:0]                 item_arp_op;
  logic [arpnc_pkg::MAC_W-1:0] item_mac;
  logic [arpnc_pkg::IP_W-1:0]  item_ip;
  logic [arpnc_pkg::IP_W-1:0]  item_target;

  logic                        out_valid;
  logic [2:0]                  out_status;
  logic                        out_send;
  logic [arpnc_pkg::MAC_W-1:0] out_reply_mac;
  logic [arpnc_pkg::IP_W-1:0]  out_reply_ip;
  logic                        out_hit;
  logic [arpnc_pkg::MAC_W-1:0] out_found_mac;
  logic                        out_resolved;
  logic [arpnc_pkg::MAC_W-1:0] out_gw_mac;

  arpnc_pkg::srch_t            srch [0:arpnc_pkg::CACHE_ENTRIES];
  arpnc_pkg::srch_t            tail;
  arpnc_pkg::cwr_t             wr;

  logic                        in_fire;
  logic                        fire;
  logic                        fmt_ok;
  logic                        frame_ok;
  logic                        is_req;
  logic                        is_rep;
  logic                        filt_ok;
  logic                        do_learn;
  logic                        gw_hit;
  logic                        use_ptr;
  logic                        send;
  logic                        is_lookup;
  arpnc_pkg::idx_t             slot;
  arpnc_pkg::idx_t             ptr_next;
  logic [2:0]                  status_next;

  assign in_ch.ready = (state == IDLE) && !cfg.valid;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg.ready   = (state == IDLE);
  assign fire        = (state == FINISH) && (!out_valid || out_ch.ready);

  assign fmt_ok = (in_ch.hardware_type == arpnc_pkg::HW_ETHERNET) &&
                  (in_ch.protocol_type == arpnc_pkg::PROTO_IPV4) &&
                  (in_ch.hardware_addr_len == arpnc_pkg::HW_LEN) &&
                  (in_ch.protocol_addr_len == arpnc_pkg::PROTO_LEN);

  always_comb begin
    srch[0]          = '0;
    srch[0].ip       = item_ip;
  end

  for (genvar g = 0; g < arpnc_pkg::CACHE_ENTRIES; g++) begin : g_cell
    arpnc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (arpnc_pkg::idx_t'(g)),
      .srch_in  (srch[g]),
      .srch_out (srch[g+1]),
      .wr       (wr)
    );
  end

  assign tail = srch[arpnc_pkg::CACHE_ENTRIES];

  always_comb begin
    frame_ok  = (item_op == arpnc_pkg::OP_FRAME) && !item_short && item_fmt_ok;
    is_req    = (item_arp_op == arpnc_pkg::OPER_REQUEST);
    is_rep    = (item_arp_op == arpnc_pkg::OPER_REPLY);
    is_lookup = (item_op != arpnc_pkg::OP_FRAME) && (item_op != arpnc_pkg::OP_NOTE);
    filt_ok   = (item_ip != '0) && (item_ip != local_ip) &&
                (item_mac != '0) && (item_mac != arpnc_pkg::MAC_ONES);
    do_learn  = (frame_ok || (item_op == arpnc_pkg::OP_NOTE)) && filt_ok;
    gw_hit    = frame_ok && (is_req || is_rep) && (item_ip == gateway_ip);
    send      = frame_ok && is_req && if_ready && (item_target == local_ip);
    use_ptr   = do_learn && !tail.hit && !tail.free;
    slot      = tail.hit ? tail.hit_idx : (tail.free ? tail.free_idx : ptr);
    ptr_next  = (ptr == arpnc_pkg::idx_t'(arpnc_pkg::CACHE_ENTRIES - 1)) ?
                '0 : ptr + arpnc_pkg::idx_t'(1);

    if (item_op == arpnc_pkg::OP_FRAME) begin
      if (item_short) begin
        status_next = arpnc_pkg::ST_SHORT;
      end else if (!item_fmt_ok) begin
        status_next = arpnc_pkg::ST_BAD_FMT;
      end else if (is_req) begin
        status_next = arpnc_pkg::ST_REQUEST;
      end else if (is_rep) begin
        status_next = arpnc_pkg::ST_REPLY;
      end else begin
        status_next = arpnc_pkg::ST_UNKNOWN;
      end
    end else if (item_op == arpnc_pkg::OP_NOTE) begin
      status_next = arpnc_pkg::ST_NOTED;
    end else begin
      status_next = arpnc_pkg::ST_LOOKUP;
    end

    wr.en  = fire && do_learn;
    wr.idx = slot;
    wr.ip  = item_ip;
    wr.mac = item_mac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cnt        <= '0;
      ptr        <= '0;
      local_ip   <= '0;
      if_ready   <= 1'b0;
      gateway_ip <= '0;
      resolved   <= 1'b0;
      gw_mac     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_fire) begin
            item_op     <= in_ch.opcode;
            item_short  <= in_ch.frame_short;
            item_fmt_ok <= fmt_ok;
            item_arp_op <= in_ch.arp_operation;
            item_mac    <= in_ch.sender_mac;
            item_ip     <= in_ch.sender_ip;
            item_target <= in_ch.tgt_ip;
            cnt         <= '0;
            state       <= SCAN;
          end
        end
        SCAN: begin
          cnt <= cnt + arpnc_pkg::idx_t'(1);
          if (cnt == arpnc_pkg::idx_t'(arpnc_pkg::CACHE_ENTRIES - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (fire) begin
            if (use_ptr) begin
              ptr <= ptr_next;
            end
            if (gw_hit) begin
              gw_mac   <= item_mac;
              resolved <= 1'b1;
            end
            out_valid     <= 1'b1;
            out_status    <= status_next;
            out_send      <= send;
            out_reply_mac <= send ? item_mac : '0;
            out_reply_ip  <= send ? item_ip : '0;
            out_hit       <= is_lookup && tail.hit;
            out_found_mac <= (is_lookup && tail.hit) ? tail.mac : '0;
            out_resolved  <= gw_hit || resolved;
            out_gw_mac    <= gw_hit ? item_mac : gw_mac;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          arpnc_pkg::REG_LOCAL_IP: begin
            local_ip <= cfg.data;
          end
          arpnc_pkg::REG_IF_READY: begin
            if_ready <= cfg.data[0];
          end
          arpnc_pkg::REG_GATEWAY_IP: begin
            gateway_ip <= cfg.data;
            resolved   <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.send_reply  = out_send;
  assign out_ch.reply_mac   = out_reply_mac;
  assign out_ch.reply_ip    = out_reply_ip;
  assign out_ch.hit         = out_hit;
  assign out_ch.found_mac   = out_found_mac;
  assign out_ch.gw_resolved = out_resolved;
  assign out_ch.gateway_mac = out_gw_mac;

  a_reply_only_on_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_send |-> out_status == arpnc_pkg::ST_REQUEST)
    else $error("reply requested for an item that is not a request");

  a_hit_only_on_lookup: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_hit |-> out_status == arpnc_pkg::ST_LOOKUP)
    else $error("cache hit reported for an item that is not a lookup");

  a_gateway_write_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && cfg.index == arpnc_pkg::REG_GATEWAY_IP |=> !resolved)
    else $error("gateway write left the resolved flag set");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(ptr) < arpnc_pkg::CACHE_ENTRIES)
    else $error("replace pointer beyond the cache");

  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state == FINISH && cnt == '0)
    else $error("cache written before the search token left the row");

endmodule

/* sim/arp_receive_and_neighbor_cache_test.sv */
// ----------------------------------------------------------------------------
// ARP receive and neighbor cache testbench
// Drives parsed ARP frames, peer notes and lookups into the block with random
// gaps, stalls the result side on its own pattern (with one long hold-off),
// and checks every result beat against a cycle-free model of the cache.
// ----------------------------------------------------------------------------
module arp_receive_and_neighbor_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_LOOKUP_ALT = 2'd3;
  localparam logic [31:0] IP_BASE       = 32'h0A00_0001;
  localparam logic [31:0] LOC_IP        = 32'h0A00_0064;
  localparam int          PHASES        = 7;
  localparam int          PHASE_ITEMS   = 165;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        frame_short;
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [7:0]  hardware_addr_len;
    logic [7:0]  protocol_addr_len;
    logic [15:0] arp_operation;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] tgt_ip;
  } arp_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_reply;
    logic [47:0] reply_mac;
    logic [31:0] reply_ip;
    logic        hit;
    logic [47:0] found_mac;
    logic        gw_resolved;
    logic [47:0] gateway_mac;
  } arp_result_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

  class arp_scoreboard_t;
    logic [31:0] local_ip;
    logic [31:0] gateway_ip;
    logic        if_ready;
    logic        entry_valid [arpnc_pkg::CACHE_ENTRIES];
    logic [31:0] entry_ip [arpnc_pkg::CACHE_ENTRIES];
    logic [47:0] entry_mac [arpnc_pkg::CACHE_ENTRIES];
    int          replace_ptr;
    logic        resolved;
    logic [47:0] gw_mac;
    arp_result_t expected_q [$];
    int          mismatches;
    int          items;
    int          replies;
    int          lookups;
    int          hits;
    int          gw_learned;

    function new();
      local_ip = '0;
      gateway_ip = '0;
      if_ready = 1'b0;
      for (int i = 0; i < arpnc_pkg::CACHE_ENTRIES; i++) begin
        entry_valid[i] = 1'b0;
        entry_ip[i] = '0;
        entry_mac[i] = '0;
      end
      replace_ptr = 0;
      resolved = 1'b0;
      gw_mac = '0;
      mismatches = 0;
      items = 0;
      replies = 0;
      lookups = 0;
      hits = 0;
      gw_learned = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        arpnc_pkg::REG_LOCAL_IP: local_ip = data;
        arpnc_pkg::REG_IF_READY: if_ready = data[0];
        arpnc_pkg::REG_GATEWAY_IP: begin
          gateway_ip = data;
          resolved = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void learn_pair(logic [31:0] ip, logic [47:0] mac);
      int match;
      int free;
      int slot;
      if (ip == '0 || ip == local_ip || mac == '0 || mac == arpnc_pkg::MAC_ONES) return;
      match = -1;
      free = -1;
      for (int i = 0; i < arpnc_pkg::CACHE_ENTRIES; i++) begin
        if (match < 0 && entry_valid[i] && entry_ip[i] == ip) match = i;
        if (free < 0 && !entry_valid[i]) free = i;
      end
      if (match >= 0) begin
        slot = match;
      end else if (free >= 0) begin
        slot = free;
      end else begin
        slot = replace_ptr;
        replace_ptr = (replace_ptr + 1) % arpnc_pkg::CACHE_ENTRIES;
      end
      entry_valid[slot] = 1'b1;
      entry_ip[slot] = ip;
      entry_mac[slot] = mac;
    endfunction

    function void gateway_learn(logic [31:0] ip, logic [47:0] mac);
      if (ip != gateway_ip) return;
      gw_mac = mac;
      learn_pair(ip, mac);
      resolved = 1'b1;
      gw_learned++;
    endfunction

    function void note_item(arp_item_t it);
      arp_result_t r;
      r = '0;
      items++;
      case (it.opcode)
        arpnc_pkg::OP_FRAME: begin
          if (it.frame_short) begin
            r.status = arpnc_pkg::ST_SHORT;
          end else if (it.hardware_type != arpnc_pkg::HW_ETHERNET ||
                       it.protocol_type != arpnc_pkg::PROTO_IPV4 ||
                       it.hardware_addr_len != arpnc_pkg::HW_LEN ||
                       it.protocol_addr_len != arpnc_pkg::PROTO_LEN) begin
            r.status = arpnc_pkg::ST_BAD_FMT;
          end else begin
            learn_pair(it.sender_ip, it.sender_mac);
            if (it.arp_operation == arpnc_pkg::OPER_REQUEST) begin
              r.status = arpnc_pkg::ST_REQUEST;
              gateway_learn(it.sender_ip, it.sender_mac);
              if (if_ready && it.tgt_ip == local_ip) begin
                r.send_reply = 1'b1;
                r.reply_mac = it.sender_mac;
                r.reply_ip = it.sender_ip;
                replies++;
              end
            end else if (it.arp_operation == arpnc_pkg::OPER_REPLY) begin
              r.status = arpnc_pkg::ST_REPLY;
              gateway_learn(it.sender_ip, it.sender_mac);
            end else begin
              r.status = arpnc_pkg::ST_UNKNOWN;
            end
          end
        end
        arpnc_pkg::OP_NOTE: begin
          r.status = arpnc_pkg::ST_NOTED;
          learn_pair(it.sender_ip, it.sender_mac);
        end
        default: begin
          r.status = arpnc_pkg::ST_LOOKUP;
          lookups++;
          for (int i = 0; i < arpnc_pkg::CACHE_ENTRIES && !r.hit; i++) begin
            if (entry_valid[i] && entry_ip[i] == it.sender_ip) begin
              r.hit = 1'b1;
              r.found_mac = entry_mac[i];
            end
          end
          if (r.hit) hits++;
        end
      endcase
      r.gw_resolved = resolved;
      r.gateway_mac = gw_mac;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
      if (got_v !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch on %s: expected %h, got %h", $realtime, name, exp_v, got_v);
      end
    endfunction

    function void check_result(arp_result_t got);
      arp_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %h", $realtime, got);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", 48'(exp_r.status), 48'(got.status));
      compare_field("send_reply", 48'(exp_r.send_reply), 48'(got.send_reply));
      compare_field("reply_mac", exp_r.reply_mac, got.reply_mac);
      compare_field("reply_ip", 48'(exp_r.reply_ip), 48'(got.reply_ip));
      compare_field("hit", 48'(exp_r.hit), 48'(got.hit));
      compare_field("found_mac", exp_r.found_mac, got.found_mac);
      compare_field("gw_resolved", 48'(exp_r.gw_resolved), 48'(got.gw_resolved));
      compare_field("gateway_mac", exp_r.gateway_mac, got.gateway_mac);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  int   burst_left;
  int   cfg_writes;

  arp_scoreboard_t sb = new();

  arpnc_in_if  in_ch();
  arpnc_out_if out_ch();
  arpnc_cfg_if cfg_ch();

  arp_receive_and_neighbor_cache uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item({in_ch.opcode, in_ch.frame_short, in_ch.hardware_type,
                      in_ch.protocol_type, in_ch.hardware_addr_len, in_ch.protocol_addr_len,
                      in_ch.arp_operation, in_ch.sender_mac, in_ch.sender_ip,
                      in_ch.tgt_ip});
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.status, out_ch.send_reply, out_ch.reply_mac, out_ch.reply_ip,
                         out_ch.hit, out_ch.found_mac, out_ch.gw_resolved,
                         out_ch.gateway_mac});
    end
  end

  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    int       hold_left;
    int       cyc;
    out_ch.ready = 1'b0;
    rx_mode = RX_ALWAYS;
    rx_left = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 48);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready = 1'b1;
          RX_RANDOM: out_ch.ready = ($urandom_range(0, 2) != 0);
          RX_SPARSE: out_ch.ready = (cyc % 4 == 0);
          default: out_ch.ready = (cyc % 2 == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_ip();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return IP_BASE + 32'(r);
    case (r)
      10: return sb.local_ip;
      11: return sb.gateway_ip;
      12: return 32'h0;
      13: return 32'hFFFF_FFFF;
      default: return 32'($urandom());
    endcase
  endfunction

  function automatic logic [47:0] pick_mac();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 48'h0;
    if (r == 1) return arpnc_pkg::MAC_ONES;
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic arp_item_t frame_item(logic [15:0] oper, logic [31:0] sip,
                                           logic [47:0] smac, logic [31:0] tip);
    arp_item_t it;
    it = '0;
    it.opcode = arpnc_pkg::OP_FRAME;
    it.hardware_type = arpnc_pkg::HW_ETHERNET;
    it.protocol_type = arpnc_pkg::PROTO_IPV4;
    it.hardware_addr_len = arpnc_pkg::HW_LEN;
    it.protocol_addr_len = arpnc_pkg::PROTO_LEN;
    it.arp_operation = oper;
    it.sender_mac = smac;
    it.sender_ip = sip;
    it.tgt_ip = tip;
    return it;
  endfunction

  function automatic arp_item_t peer_item(logic [1:0] op, logic [31:0] ip, logic [47:0] mac);
    arp_item_t it;
    it = '0;
    it.opcode = op;
    it.sender_ip = ip;
    it.sender_mac = mac;
    return it;
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t it;
    int k;
    int j;
    it = 179'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    k = $urandom_range(0, 99);
    if (k < 58) begin
      j = $urandom_range(0, 19);
      it = frame_item(j < 9 ? arpnc_pkg::OPER_REQUEST :
                      (j < 17 ? arpnc_pkg::OPER_REPLY : it.arp_operation),
                      pick_ip(), pick_mac(),
                      ($urandom_range(0, 2) == 0) ? sb.local_ip : pick_ip());
    end else if (k < 68) begin
      j = $urandom_range(0, 4);
      if (j != 0)
        it = frame_item(it.arp_operation, pick_ip(), pick_mac(), it.tgt_ip);
      it.opcode = arpnc_pkg::OP_FRAME;
      case (j)
        0: it.frame_short = 1'b1;
        1: it.hardware_type = 16'($urandom());
        2: it.protocol_type = 16'($urandom());
        3: it.hardware_addr_len = 8'($urandom());
        default: it.protocol_addr_len = 8'($urandom());
      endcase
    end else if (k < 80) begin
      it.opcode = arpnc_pkg::OP_NOTE;
      it.sender_ip = pick_ip();
      it.sender_mac = pick_mac();
    end else begin
      it.opcode = (k < 96) ? arpnc_pkg::OP_LOOKUP : OP_LOOKUP_ALT;
      it.sender_ip = pick_ip();
    end
    return it;
  endfunction

  task automatic offer(input arp_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    {in_ch.opcode, in_ch.frame_short, in_ch.hardware_type, in_ch.protocol_type,
     in_ch.hardware_addr_len, in_ch.protocol_addr_len, in_ch.arp_operation,
     in_ch.sender_mac, in_ch.sender_ip, in_ch.tgt_ip} = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    arp_item_t it;
    int        wait_cnt;
    rst = 1'b1;
    hold_req = 1'b0;
    burst_left = 0;
    cfg_writes = 0;
    {in_ch.valid, in_ch.opcode, in_ch.frame_short, in_ch.hardware_type, in_ch.protocol_type,
     in_ch.hardware_addr_len, in_ch.protocol_addr_len, in_ch.arp_operation,
     in_ch.sender_mac, in_ch.sender_ip, in_ch.tgt_ip} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = arpnc_pkg::REG_LOCAL_IP;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(arpnc_pkg::REG_LOCAL_IP, LOC_IP);
    write_reg(arpnc_pkg::REG_IF_READY, 32'h1);
    write_reg(arpnc_pkg::REG_GATEWAY_IP, IP_BASE);

    it = frame_item(arpnc_pkg::OPER_REQUEST, IP_BASE + 4, 48'h0200_0000_0005, LOC_IP);
    it.frame_short = 1'b1;
    offer(it);
    it.frame_short = 1'b0;
    it.hardware_type = 16'hFFFF;
    offer(it);
    it.hardware_type = arpnc_pkg::HW_ETHERNET;
    it.protocol_type = 16'h86DD;
    offer(it);
    it.protocol_type = arpnc_pkg::PROTO_IPV4;
    it.hardware_addr_len = 8'hFF;
    offer(it);
    it.hardware_addr_len = arpnc_pkg::HW_LEN;
    it.protocol_addr_len = 8'h00;
    offer(it);
    offer(frame_item(arpnc_pkg::OPER_REQUEST, IP_BASE + 4, 48'h0200_0000_0005, LOC_IP));
    offer(frame_item(arpnc_pkg::OPER_REQUEST, IP_BASE + 5, 48'h0200_0000_0006, IP_BASE + 6));
    offer(frame_item(arpnc_pkg::OPER_REPLY, IP_BASE, 48'h0200_0000_00AA, 32'hFFFF_FFFF));
    offer(frame_item(16'hFFFF, IP_BASE + 6, 48'h0200_0000_0007, 32'h0));
    offer(peer_item(arpnc_pkg::OP_NOTE, IP_BASE + 7, 48'hFFFF_FFFF_FFFE));
    offer(peer_item(arpnc_pkg::OP_LOOKUP, IP_BASE + 4, '0));
    offer(peer_item(arpnc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0));
    offer(peer_item(OP_LOOKUP_ALT, IP_BASE + 6, '0));
    offer(peer_item(arpnc_pkg::OP_NOTE, 32'h0, 48'h0200_0000_0010));
    offer(peer_item(arpnc_pkg::OP_NOTE, LOC_IP, 48'h0200_0000_0011));
    offer(peer_item(arpnc_pkg::OP_NOTE, IP_BASE + 9, 48'h0));
    offer(peer_item(arpnc_pkg::OP_NOTE, IP_BASE + 9, arpnc_pkg::MAC_ONES));
    offer(frame_item(arpnc_pkg::OPER_REQUEST, IP_BASE, arpnc_pkg::MAC_ONES, LOC_IP));
    offer(peer_item(arpnc_pkg::OP_NOTE, IP_BASE + 8, 48'h0200_0000_0012));
    offer(peer_item(arpnc_pkg::OP_NOTE, IP_BASE + 9, 48'h0200_0000_0013));
    offer(peer_item(arpnc_pkg::OP_NOTE, 32'hC0A8_0001, 48'h0200_0000_0014));
    offer(peer_item(arpnc_pkg::OP_NOTE, 32'hC0A8_0002, 48'h0200_0000_0015));
    offer(peer_item(arpnc_pkg::OP_LOOKUP, IP_BASE + 4, '0));
    offer(peer_item(arpnc_pkg::OP_LOOKUP, 32'hC0A8_0002, '0));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(arpnc_pkg::REG_LOCAL_IP, 32'hFFFF_FFFF);
          write_reg(arpnc_pkg::REG_IF_READY, 32'h1);
          write_reg(arpnc_pkg::REG_GATEWAY_IP, 32'h0);
        end
        1: begin
          write_reg(arpnc_pkg::REG_LOCAL_IP, 32'h0);
          write_reg(arpnc_pkg::REG_IF_READY, 32'hFFFF_FFFF);
          write_reg(arpnc_pkg::REG_GATEWAY_IP, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(arpnc_pkg::REG_LOCAL_IP, IP_BASE + 3);
          write_reg(arpnc_pkg::REG_IF_READY, 32'hFFFF_FFFE);
          write_reg(arpnc_pkg::REG_GATEWAY_IP, IP_BASE);
          hold_req = 1'b1;
        end
        default: begin
          write_reg(arpnc_pkg::REG_LOCAL_IP, pick_ip());
          write_reg(arpnc_pkg::REG_IF_READY, $urandom());
          write_reg(arpnc_pkg::REG_GATEWAY_IP, pick_ip());
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) offer(rand_item());
    end

    in_ch.valid = 1'b0;
    wait_cnt = 0;
    while (sb.pending() != 0 && wait_cnt < 5000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (40) @(negedge clk);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("Covered %0d items over %0d register writes: %0d lookups (%0d hits), %0d replies.",
             sb.items, cfg_writes, sb.lookups, sb.hits, sb.replies);
    $display("Gateway learned %0d times; %0d mismatches.", sb.gw_learned, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
